FILE: rtl/u8s_pkg.sv
// Shared types, constants and the sequence judging function for the UTF-8 sanitiser.
package u8s_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [7:0] CONV_HI = 8'hC0;
  localparam logic [7:0] CONV_LO = 8'h80;

  typedef enum logic [1:0] {
    V_WAIT,
    V_CONV,
    V_COPY
  } verdict_kind_t;

  typedef struct packed {
    verdict_kind_t kind;
    logic [2:0]    len;
  } verdict_t;

  // One accepted request's worth of decided bytes, oldest in byte 0.
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      used;
    logic [3:0]      conv;
    logic [3:0]      rep;
    logic            str_end;
  } entry_t;

  // Judge the front byte of a window of avail bytes (front in bits 7:0).
  function automatic verdict_t judge(logic [31:0] w, logic [2:0] avail, logic last);
    verdict_t   v;
    logic [2:0] need;
    logic       fin;
    v.kind = V_COPY;
    v.len  = 3'd1;
    need   = 3'd1;
    fin    = 1'b0;
    if (!w[7]) begin
      need = 3'd1;
    end else if (w[7:5] == 3'b110) begin
      need = 3'd2;
    end else if (w[7:4] == 4'b1110) begin
      need = 3'd3;
    end else if (w[7:3] == 5'b11110) begin
      need = 3'd4;
    end else begin
      v.kind = V_CONV;
      fin    = 1'b1;
    end
    for (int i = 1; i < 4; i++) begin
      if (!fin && (3'(i) < need)) begin
        if (3'(i) >= avail) begin
          v.kind = last ? V_CONV : V_WAIT;
          fin    = 1'b1;
        end else if (w[8*i+6 +: 2] != 2'b10) begin
          v.kind = V_CONV;
          fin    = 1'b1;
        end
      end
    end
    if (!fin) v.len = need;
    return v;
  endfunction

endpackage

FILE: rtl/u8s_front.sv
// Front end: holds undecided bytes and decides which bytes are copied or converted.
module u8s_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  logic [7:0]      s_tdata,
  input  logic            s_tlast,
  output logic            push,
  output u8s_pkg::entry_t push_entry,
  input  logic            full
);
  import u8s_pkg::*;

  logic [2:0][7:0] pend;
  logic [1:0]      pend_cnt;
  logic            repair_seen;

  logic [3:0][7:0] bufb;
  logic [2:0]      n;
  logic [2:0]      pos;
  logic            stop;
  logic [3:0]      conv;
  logic [3:0]      rep;
  logic            acc;
  logic [31:0]     win;
  logic [31:0]     rest;
  verdict_t        v;
  logic            take;

  assign s_tready = !full;
  assign take     = s_tvalid && s_tready;

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      if (2'(j) < pend_cnt && j < 3) begin
        bufb[j] = pend[j[1:0]];
      end else if (3'(j) == {1'b0, pend_cnt}) begin
        bufb[j] = s_tdata;
      end else begin
        bufb[j] = 8'h00;
      end
    end
    n    = {1'b0, pend_cnt} + 3'd1;
    pos  = 3'd0;
    stop = 1'b0;
    conv = 4'b0000;
    win  = 32'h0;
    v    = '{kind: V_WAIT, len: 3'd0};
    // each pass settles one front byte; at most four bytes in play
    for (int i = 0; i < 4; i++) begin
      if (!stop && (pos < n)) begin
        win = bufb >> {pos, 3'b000};
        v   = judge(win, n - pos, s_tlast);
        if (v.kind == V_WAIT) begin
          stop = 1'b1;
        end else if (v.kind == V_CONV) begin
          conv[pos[1:0]] = 1'b1;
          pos = pos + 3'd1;
        end else begin
          pos = pos + v.len;
        end
      end
    end
    acc = repair_seen;
    for (int p = 0; p < 4; p++) begin
      acc    = acc | conv[p];
      rep[p] = acc;
    end
    rest = bufb >> {pos, 3'b000};
  end

  assign push               = take && (pos != 3'd0);
  assign push_entry.bytes   = bufb;
  assign push_entry.used    = pos;
  assign push_entry.conv    = conv;
  assign push_entry.rep     = rep;
  assign push_entry.str_end = s_tlast;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_cnt    <= 2'd0;
      repair_seen <= 1'b0;
    end else if (take) begin
      if (s_tlast) begin
        pend_cnt    <= 2'd0;
        repair_seen <= 1'b0;
      end else begin
        pend_cnt    <= 2'(n - pos);
        repair_seen <= repair_seen | (conv != 4'b0000);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      pend[0] <= rest[7:0];
      pend[1] <= rest[15:8];
      pend[2] <= rest[23:16];
    end
  end

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    take && s_tlast |=> pend_cnt == 2'd0 && !repair_seen)
    else $error("string end left bytes or repair flag behind");

  a_front_not_ascii: assert property (@(posedge clk) disable iff (rst)
    pend_cnt != 2'd0 |-> pend[0][7])
    else $error("ASCII byte left waiting");

  a_second_is_cont: assert property (@(posedge clk) disable iff (rst)
    pend_cnt >= 2'd2 |-> pend[1][7:6] == 2'b10)
    else $error("waiting byte after lead is not a continuation");

endmodule

FILE: rtl/u8s_fifo.sv
// Short queue of decided requests between the front and back ends.
module u8s_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  u8s_pkg::entry_t push_entry,
  output logic            full,
  input  logic            pop,
  output u8s_pkg::entry_t head,
  output logic            empty
);
  import u8s_pkg::*;

  entry_t                store [QUEUE_DEPTH];
  logic [QPTR_W-1:0]     wr_ptr;
  logic [QPTR_W-1:0]     rd_ptr;
  logic [QPTR_W:0]       count;

  assign full  = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) store[wr_ptr] <= push_entry;
  end

endmodule

FILE: rtl/u8s_back.sv
// Back end: expands queued requests into output bytes through a registered output stage.
module u8s_back (
  input  logic            clk,
  input  logic            rst,
  input  u8s_pkg::entry_t head,
  input  logic            q_valid,
  output logic            pop,
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [7:0]      m_tdata,
  output logic            m_tlast,
  output logic [1:0]      m_tuser
);
  import u8s_pkg::*;

  logic [1:0] p;
  logic       half;
  logic [7:0] cur;
  logic       is_conv;
  logic [7:0] byte_out;
  logic       last;
  logic       adv;

  always_comb begin
    cur     = head.bytes[p];
    is_conv = head.conv[p];
    if (is_conv) begin
      byte_out = half ? (CONV_LO | {2'b00, cur[5:0]}) : (CONV_HI | {6'd0, cur[7:6]});
    end else begin
      byte_out = cur;
    end
    last = ({1'b0, p} == head.used - 3'd1) && (!is_conv || half);
  end

  assign adv = q_valid && (!m_tvalid || m_tready);
  assign pop = adv && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      p        <= 2'd0;
      half     <= 1'b0;
    end else if (adv) begin
      m_tvalid <= 1'b1;
      if (last) begin
        p    <= 2'd0;
        half <= 1'b0;
      end else if (is_conv && !half) begin
        half <= 1'b1;
      end else begin
        p    <= p + 2'd1;
        half <= 1'b0;
      end
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata    <= byte_out;
      m_tlast    <= last && head.str_end;
      m_tuser[0] <= last;
      m_tuser[1] <= head.rep[p];
    end
  end

endmodule

FILE: rtl/utf8_sanitize_latin1_fallback.sv
// Top level of the UTF-8 sanitiser with Latin-1 fallback.
//
//  channel | dir | handshake          | payload
//  s_*     | in  | s_tvalid/s_tready  | tdata = data_byte, tlast = string_end
//  m_*     | out | m_tvalid/m_tready  | tdata = out_byte, tlast = out_string_end,
//          |     |                    | tuser = {repaired, run_last}
//
// One input byte is taken per cycle while the request queue (four entries) has room.
// The back end drains one output byte per cycle unless m_tready stalls it: a request yields 1 to 8 bytes,
// so a run of converted bytes holds input off once the queue fills.
// Reset is synchronous and clears the waiting bytes, the queue and the output stage.
// Output stalls back up through the queue only; the front keeps taking bytes until full.
module utf8_sanitize_latin1_fallback (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] data_byte
  input  logic       s_tlast,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic       m_tlast,
  output logic [1:0] m_tuser    // [0] run_last, [1] repaired
);
  import u8s_pkg::*;

  logic   push;
  entry_t push_entry;
  logic   full;
  logic   pop;
  entry_t head;
  logic   empty;

  u8s_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .push       (push),
    .push_entry (push_entry),
    .full       (full)
  );

  u8s_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .pop        (pop),
    .head       (head),
    .empty      (empty)
  );

  u8s_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .q_valid  (!empty),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule
